@@ design/bce_pkg.sv @@
// Shared constants, types and helpers of the BC1/BC3 block encoder.
package bce_pkg;

  localparam int PIXELS     = 16;
  localparam int PIX_W      = $clog2(PIXELS);
  localparam int Q_W        = 11;
  localparam int DARK_LIMIT = 2601;

  // configuration register indexes (byte address is 4 * index)
  localparam int REG_ALPHA_MODE = 0;

  typedef struct packed {
    logic             load;
    logic             first;
    logic             prep;
    logic             ends;
    logic             eval;
    logic             sel_alpha;
    logic [1:0]       step;
    logic [PIX_W-1:0] wr_addr;
    logic [PIX_W-1:0] rd_addr;
  } cmd_t;

  function automatic logic [15:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return {8'd0, t[15:8]};
  endfunction

  function automatic logic [15:0] code565(input logic [Q_W-1:0] r, input logic [Q_W-1:0] g,
                                          input logic [Q_W-1:0] b);
    logic [15:0] cr, cg, cb;
    cr = div255(16'((17'(r) * 17'd31) >> 2));
    cg = div255(16'((17'(g) * 17'd63) >> 2));
    cb = div255(16'((17'(b) * 17'd31) >> 2));
    return {cr[4:0], cg[5:0], cb[4:0]};
  endfunction

endpackage

@@ design/bce_ctrl.sv @@
// Sequencer of the block encoder: load, endpoint setup, index search, word output.
module bce_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          alpha_mode,
  output logic          busy,
  output logic          valid,
  output logic          last_word,
  output bce_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {IDLE, PREP, ENDS, FETCH, EVAL, OUT_A, OUT_C} state_t;

  state_t                    state;
  logic [bce_pkg::PIX_W-1:0] count;
  logic [bce_pkg::PIX_W-1:0] pix;
  logic [1:0]                step;
  logic                      mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      pix   <= '0;
      step  <= '0;
      mode  <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (start) begin
            count <= count + 1'b1;
            if (count == bce_pkg::PIX_W'(bce_pkg::PIXELS - 1)) begin
              mode  <= alpha_mode;
              state <= PREP;
            end
          end
        end
        PREP: state <= ENDS;
        ENDS: begin
          pix   <= '0;
          state <= FETCH;
        end
        FETCH: begin
          step  <= '0;
          state <= EVAL;
        end
        EVAL: begin
          step <= step + 1'b1;
          if (step == 2'd3) begin
            if (pix == bce_pkg::PIX_W'(bce_pkg::PIXELS - 1)) begin
              state <= mode ? OUT_A : OUT_C;
            end else begin
              pix   <= pix + 1'b1;
              state <= FETCH;
            end
          end
        end
        OUT_A: state <= OUT_C;
        OUT_C: state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

  assign busy      = (state != IDLE);
  assign valid     = (state == OUT_A) || (state == OUT_C);
  assign last_word = (state == OUT_C);

  always_comb begin
    cmd           = '0;
    cmd.load      = (state == IDLE) && start;
    cmd.first     = (count == '0);
    cmd.prep      = (state == PREP);
    cmd.ends      = (state == ENDS);
    cmd.eval      = (state == EVAL);
    cmd.sel_alpha = (state == OUT_A);
    cmd.step      = step;
    cmd.wr_addr   = count;
    cmd.rd_addr   = pix;
  end

endmodule

@@ design/bce_datapath.sv @@
// Pixel store, endpoint tracking, palettes and nearest-index search.
module bce_datapath (
  input  logic          clk,
  input  bce_pkg::cmd_t cmd,
  input  logic [7:0]    red,
  input  logic [7:0]    green,
  input  logic [7:0]    blue,
  input  logic [7:0]    alpha,
  output logic [63:0]   block_word
);

  localparam int QW = bce_pkg::Q_W;

  logic [31:0] store [bce_pkg::PIXELS];
  logic [31:0] rd_px;

  logic [15:0] lo_code, hi_code, in_code;
  logic [23:0] lo_px, hi_px;
  logic [7:0]  amin, amax;
  logic        eq, dark;

  logic [11:0] pal [4][3];
  logic [12:0] apal [8];
  logic [15:0] c0, c1;
  logic [7:0]  abyte_hi, abyte_lo;

  logic [25:0] cbest_d;
  logic [1:0]  cbest_i;
  logic [12:0] abest_d;
  logic [2:0]  abest_i;
  logic [31:0] cidx;
  logic [47:0] aidx;

  assign in_code = bce_pkg::code565({1'b0, red, 2'b00}, {1'b0, green, 2'b00},
                                    {1'b0, blue, 2'b00});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      store[cmd.wr_addr] <= {alpha, blue, green, red};
      if (cmd.first || in_code < lo_code) begin
        lo_code <= in_code;
        lo_px   <= {blue, green, red};
      end
      if (cmd.first || in_code >= hi_code) begin
        hi_code <= in_code;
        hi_px   <= {blue, green, red};
      end
      if (cmd.first || alpha < amin) amin <= alpha;
      if (cmd.first || alpha > amax) amax <= alpha;
    end
    rd_px <= store[cmd.rd_addr];
  end

  // Endpoint setup
  logic [19:0] sumsq;
  always_comb begin
    sumsq = 20'(16'(hi_px[7:0] * hi_px[7:0])) + 20'(16'(hi_px[15:8] * hi_px[15:8]))
          + 20'(16'(hi_px[23:16] * hi_px[23:16]));
  end

  logic [QW-1:0] mx [3];
  logic [QW-1:0] mn [3];
  logic [9:0]    amx, amn;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mx[k] = {1'b0, hi_px[8*k +: 8], 2'b00};
      mn[k] = {1'b0, lo_px[8*k +: 8], 2'b00};
      if (eq && dark) mx[k] = mx[k] + QW'(255);
      if (eq && !dark) mn[k] = {2'b00, lo_px[8*k +: 8], 1'b0};
    end
    amx = {amax, 2'b00};
    amn = {amin, 2'b00};
    if (amax == amin) begin
      if (amax == 8'd0) amx = 10'd102;
      else amn = 10'(11'(amin) * 11'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      eq   <= (lo_code == hi_code);
      dark <= ({sumsq, 2'b00} < 22'(bce_pkg::DARK_LIMIT));
    end
    if (cmd.ends) begin
      c0 <= bce_pkg::code565(mx[0], mx[1], mx[2]);
      c1 <= bce_pkg::code565(mn[0], mn[1], mn[2]);
      for (int k = 0; k < 3; k++) begin
        pal[0][k] <= 12'(mx[k] * 2'd3);
        pal[1][k] <= 12'(mn[k] * 2'd3);
        pal[2][k] <= 12'({mx[k], 1'b0} + mn[k]);
        pal[3][k] <= 12'(mx[k] + {mn[k], 1'b0});
      end
      apal[0] <= 13'(amx * 3'd7);
      apal[1] <= 13'(amn * 3'd7);
      for (int e = 2; e < 8; e++) begin
        apal[e] <= 13'(amx * 4'(8 - e)) + 13'(amn * 4'(e - 1));
      end
      abyte_hi <= amx[9:2];
      abyte_lo <= amn[9:2];
    end
  end

  // Index search: one color entry and two alpha entries per cycle in EVAL
  logic [11:0] cp [3];
  logic [11:0] cdiff [3];
  logic [25:0] cd;
  logic        ctake;
  logic [12:0] ap, da, db, d1;
  logic [2:0]  ea, eb, i1;
  logic        ta, tb;

  always_comb begin
    cd = '0;
    for (int k = 0; k < 3; k++) begin
      cp[k]    = {1'b0, rd_px[8*k +: 8], 3'b000} + {2'b00, rd_px[8*k +: 8], 2'b00};
      cdiff[k] = (cp[k] > pal[cmd.step][k]) ? cp[k] - pal[cmd.step][k]
                                            : pal[cmd.step][k] - cp[k];
      cd       = cd + 26'(cdiff[k] * cdiff[k]);
    end
    ctake = (cmd.step == 2'd0) || (cd < cbest_d);

    ap = {rd_px[31:24], 5'b00000} - {2'b00, rd_px[31:24], 2'b00};
    ea = {cmd.step, 1'b0};
    eb = {cmd.step, 1'b1};
    da = (ap > apal[ea]) ? ap - apal[ea] : apal[ea] - ap;
    db = (ap > apal[eb]) ? ap - apal[eb] : apal[eb] - ap;
    ta = (cmd.step == 2'd0) || (da < abest_d);
    d1 = ta ? da : abest_d;
    i1 = ta ? ea : abest_i;
    tb = (db < d1);
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      cbest_d <= ctake ? cd : cbest_d;
      cbest_i <= ctake ? cmd.step : cbest_i;
      abest_d <= tb ? db : d1;
      abest_i <= tb ? eb : i1;
      if (cmd.step == 2'd3) begin
        cidx <= {(ctake ? cmd.step : cbest_i), cidx[31:2]};
        aidx <= {(tb ? eb : i1), aidx[47:3]};
      end
    end
  end

  assign block_word = cmd.sel_alpha ? {aidx, abyte_lo, abyte_hi} : {cidx, c1, c0};

endmodule

@@ design/bc1_bc3_block_encoder.sv @@
// Top level of the BC1/BC3 4x4 block encoder.
//
//  channel   signals                              handshake
//  pixel in  red green blue alpha                 start & !busy
//  word out  block_word last_word                 valid, one cycle
//  config    psel penable pwrite paddr pwdata ... APB, pready high
//
// A block's first fifteen pixels take one cycle each. The sixteenth starts
// the setup states PREP and ENDS and an index search of one fetch from the
// pixel store and four palette steps through the shared distance unit per
// pixel, then one word (BC1) or two words (BC3). rst clears the sequencer,
// pixel count and alpha_mode. The receiver cannot stall.
module bc1_bc3_block_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [7:0]  alpha,
  output logic        valid,
  output logic [63:0] block_word,
  output logic        last_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  bce_pkg::cmd_t cmd;
  logic          alpha_mode;
  logic          sel_mode;

  assign pready   = 1'b1;
  assign sel_mode = (paddr[2] == 1'(bce_pkg::REG_ALPHA_MODE));

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_mode <= 1'b0;
    end else if (psel && penable && pwrite && sel_mode) begin
      alpha_mode <= pwdata[0];
    end
  end

  assign prdata = sel_mode ? {31'd0, alpha_mode} : 32'd0;

  bce_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .alpha_mode (alpha_mode),
    .busy       (busy),
    .valid      (valid),
    .last_word  (last_word),
    .cmd        (cmd)
  );

  bce_datapath u_datapath (
    .clk        (clk),
    .cmd        (cmd),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha      (alpha),
    .block_word (block_word)
  );

endmodule
